// ----- design/pkfs_pkg.sv -----
// shared types and constants of the packed-font stream scanner
package pkfs_pkg;

    localparam logic [7:0] OP_XXX1     = 8'd240;
    localparam logic [7:0] OP_XXX4     = 8'd243;
    localparam logic [7:0] OP_YYY      = 8'd244;
    localparam logic [7:0] OP_POST     = 8'd245;
    localparam logic [7:0] OP_NOOP     = 8'd246;
    localparam logic [7:0] OP_PRE      = 8'd247;
    localparam logic [7:0] OP_UNDEF_LO = 8'd248;
    localparam logic [7:0] PRE_ID      = 8'd89;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_PRE  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ID    = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        PH_OPCODE,
        PH_XLEN,
        PH_SKIP,
        PH_PRE_ID,
        PH_PRE_CLEN,
        PH_PRE_COMMENT,
        PH_PRE_DS,
        PH_PRE_CS,
        PH_PRE_HR,
        PH_PRE_VR,
        PH_CH_LEN,
        PH_CH_CODE,
        PH_FAILED
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] char_code;
        logic [31:0] packet_length;
        logic [7:0]  flag_byte;
        logic [31:0] data_offset;
        logic [31:0] design_size;
        logic [31:0] checksum;
        logic [31:0] h_resolution;
        logic [31:0] v_resolution;
        logic [7:0]  comment_length;
        logic [1:0]  status;
        logic        last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } push_t;

endpackage

// ----- design/pk_font_stream_scanner_core.sv -----
// top level of the packed-font stream scanner
// Scans a packed-font file one byte per word and reports the preamble, every
// character header and the end of the file. A byte is taken every cycle in which
// the byte input does not stall: its opcode or field byte is decoded straight
// from the scan state registers and the results go into a four-word output
// queue. The final byte of a file that also completes a header gives two
// results; the byte input stalls only while the output queue has fewer than
// two free words, so with the output side never stalled the block runs at one
// byte per cycle. After the final byte all state returns to its reset values
// and the next byte starts a new file at position 0.
module pk_font_stream_scanner_core
    import pkfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      data_valid,
    output logic      data_stall,
    input  in_word_t  data_word,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result_word
);

    phase_t      phase_reg,       phase_next;
    logic [2:0]  count_reg,       count_next;
    logic [31:0] acc_reg,         acc_next;
    logic [31:0] skip_reg,        skip_next;
    logic [31:0] pos_reg,         pos_next;
    logic [7:0]  flag_reg,        flag_next;
    logic [31:0] length_reg,      length_next;
    logic [31:0] dsize_reg,       dsize_next;
    logic [31:0] csum_reg,        csum_next;
    logic [31:0] hres_reg,        hres_next;
    logic [7:0]  clen_reg,        clen_next;
    logic        failed_reg,      failed_next;

    logic        room;
    logic        accept;
    logic [7:0]  b;
    logic [31:0] acc_shift;
    logic [2:0]  count_dec;
    logic        field_done;
    logic        hdr_valid;
    out_word_t   hdr_word;
    out_word_t   eof_word;
    logic [31:0] char_len;
    logic [31:0] skip_dec;
    push_t       push;

    assign data_stall = !room;
    assign accept     = data_valid && room;
    assign b          = data_word.data_byte;
    assign acc_shift  = {acc_reg[23:0], b};
    assign count_dec  = (count_reg != 3'd0) ? count_reg - 3'd1 : count_reg;
    assign field_done = (count_dec == 3'd0);
    assign skip_dec   = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        skip_next   = skip_reg;
        pos_next    = pos_reg + 32'd1;
        flag_next   = flag_reg;
        length_next = length_reg;
        dsize_next  = dsize_reg;
        csum_next   = csum_reg;
        hres_next   = hres_reg;
        clen_next   = clen_reg;
        failed_next = failed_reg;
        hdr_valid   = 1'b0;
        hdr_word    = '0;
        char_len    = acc_shift;

        case (phase_reg)
            PH_OPCODE:
            begin
                if (b >= OP_XXX1 && b <= OP_XXX4)
                begin
                    acc_next   = '0;
                    count_next = 3'(b - OP_XXX1) + 3'd1;
                    phase_next = PH_XLEN;
                end
                else if (b == OP_YYY)
                begin
                    skip_next  = 32'd4;
                    phase_next = PH_SKIP;
                end
                else if (b == OP_PRE)
                begin
                    phase_next = PH_PRE_ID;
                end
                else if (b == OP_POST || b == OP_NOOP || b >= OP_UNDEF_LO)
                begin
                    phase_next = PH_OPCODE;
                end
                else
                begin
                    flag_next  = b;
                    acc_next   = '0;
                    count_next = (b[2:0] == 3'd7) ? 3'd4 : (b[2] ? 3'd2 : 3'd1);
                    phase_next = PH_CH_LEN;
                end
            end
            PH_XLEN:
            begin
                acc_next   = acc_shift;
                count_next = count_dec;
                if (field_done)
                begin
                    skip_next  = acc_shift;
                    phase_next = (acc_shift != 32'd0) ? PH_SKIP : PH_OPCODE;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = PH_OPCODE;
                end
            end
            PH_PRE_ID:
            begin
                if (b != PRE_ID)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_FAILED;
                end
                else
                begin
                    phase_next = PH_PRE_CLEN;
                end
            end
            PH_PRE_CLEN:
            begin
                clen_next  = b;
                acc_next   = '0;
                count_next = 3'd4;
                skip_next  = {24'd0, b};
                phase_next = (b != 8'd0) ? PH_PRE_COMMENT : PH_PRE_DS;
            end
            PH_PRE_COMMENT:
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = PH_PRE_DS;
                end
            end
            PH_PRE_DS:
            begin
                acc_next   = acc_shift;
                count_next = count_dec;
                if (field_done)
                begin
                    dsize_next = acc_shift;
                    acc_next   = '0;
                    count_next = 3'd4;
                    phase_next = PH_PRE_CS;
                end
            end
            PH_PRE_CS:
            begin
                acc_next   = acc_shift;
                count_next = count_dec;
                if (field_done)
                begin
                    csum_next  = acc_shift;
                    acc_next   = '0;
                    count_next = 3'd4;
                    phase_next = PH_PRE_HR;
                end
            end
            PH_PRE_HR:
            begin
                acc_next   = acc_shift;
                count_next = count_dec;
                if (field_done)
                begin
                    hres_next  = acc_shift;
                    acc_next   = '0;
                    count_next = 3'd4;
                    phase_next = PH_PRE_VR;
                end
            end
            PH_PRE_VR:
            begin
                acc_next   = acc_shift;
                count_next = count_dec;
                if (field_done)
                begin
                    hdr_valid               = 1'b1;
                    hdr_word.kind           = KIND_PRE;
                    hdr_word.data_offset    = pos_reg - {24'd0, clen_reg} - 32'd15;
                    hdr_word.design_size    = dsize_reg;
                    hdr_word.checksum       = csum_reg;
                    hdr_word.h_resolution   = hres_reg;
                    hdr_word.v_resolution   = acc_shift;
                    hdr_word.comment_length = clen_reg;
                    phase_next              = PH_OPCODE;
                end
            end
            PH_CH_LEN:
            begin
                acc_next   = acc_shift;
                count_next = count_dec;
                if (flag_reg[2:0] != 3'd7)
                begin
                    if (flag_reg[2])
                    begin
                        char_len = acc_shift + {14'd0, flag_reg[1:0], 16'd0};
                    end
                    else
                    begin
                        char_len = acc_shift + {22'd0, flag_reg[1:0], 8'd0};
                    end
                end
                if (field_done)
                begin
                    length_next = char_len;
                    acc_next    = '0;
                    count_next  = (flag_reg[2:0] == 3'd7) ? 3'd4 : 3'd1;
                    phase_next  = PH_CH_CODE;
                end
            end
            PH_CH_CODE:
            begin
                acc_next   = acc_shift;
                count_next = count_dec;
                if (field_done)
                begin
                    hdr_valid              = 1'b1;
                    hdr_word.kind          = KIND_CHAR;
                    hdr_word.char_code     = acc_shift;
                    hdr_word.packet_length = length_reg;
                    hdr_word.flag_byte     = flag_reg;
                    hdr_word.data_offset   = pos_reg + 32'd1;
                    skip_next              = length_reg;
                    phase_next = (length_reg != 32'd0) ? PH_SKIP : PH_OPCODE;
                end
            end
            default:
            begin
                phase_next = PH_FAILED;
            end
        endcase

        eof_word             = '0;
        eof_word.kind        = KIND_EOF;
        eof_word.data_offset = pos_reg + 32'd1;
        eof_word.last_of_run = 1'b1;
        if (failed_next)
        begin
            eof_word.status = STATUS_BAD_ID;
        end
        else if (phase_next == PH_OPCODE || phase_next == PH_SKIP)
        begin
            eof_word.status = STATUS_OK;
        end
        else
        begin
            eof_word.status = STATUS_TRUNCATED;
        end
        hdr_word.last_of_run = !data_word.final_byte;

        push.first  = hdr_valid ? hdr_word : eof_word;
        push.second = eof_word;
        push.count  = '0;
        if (accept)
        begin
            push.count = {1'b0, hdr_valid} + {1'b0, data_word.final_byte};
        end

        if (data_word.final_byte)
        begin
            phase_next  = PH_OPCODE;
            count_next  = '0;
            acc_next    = '0;
            skip_next   = '0;
            pos_next    = '0;
            flag_next   = '0;
            length_next = '0;
            dsize_next  = '0;
            csum_next   = '0;
            hres_next   = '0;
            clen_next   = '0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPCODE;
            count_reg  <= '0;
            acc_reg    <= '0;
            skip_reg   <= '0;
            pos_reg    <= '0;
            flag_reg   <= '0;
            length_reg <= '0;
            dsize_reg  <= '0;
            csum_reg   <= '0;
            hres_reg   <= '0;
            clen_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            acc_reg    <= acc_next;
            skip_reg   <= skip_next;
            pos_reg    <= pos_next;
            flag_reg   <= flag_next;
            length_reg <= length_next;
            dsize_reg  <= dsize_next;
            csum_reg   <= csum_next;
            hres_reg   <= hres_next;
            clen_reg   <= clen_next;
            failed_reg <= failed_next;
        end
    end

    pkfs_out_queue u_out_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

// ----- design/pkfs_out_queue.sv -----
// small result queue that takes up to two words per cycle and hands out one per cycle unless the result side stalls
module pkfs_out_queue
    import pkfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      room,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result_word
);

    out_word_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg;
    logic [QUEUE_AW:0]       count_next;
    logic                    pop;

    assign pop          = result_valid && !result_stall;
    assign result_valid = (count_reg != '0);
    assign result_word  = mem_reg[rd_ptr_reg];
    assign room         = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + (QUEUE_AW+1)'(push.count) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + QUEUE_AW'(1)] <= push.second;
        end
    end

endmodule
